// ----- src/tlsrd_pkg.sv -----
// Shared constants for the record deframer: header layout and result kinds.
// No dependencies; imported by tls_like_record_deframer_unit.
`default_nettype none

package tlsrd_pkg;

    // Header layout
    localparam logic [7:0] TYPE_APPDATA = 8'h17;
    localparam logic [2:0] HEADER_LEN   = 3'd5;

    // Header byte positions
    localparam logic [2:0] HDR_TYPE     = 3'd0;
    localparam logic [2:0] HDR_VER_HI   = 3'd1;
    localparam logic [2:0] HDR_VER_LO   = 3'd2;
    localparam logic [2:0] HDR_LEN_HI   = 3'd3;

    // Width of header plus payload length sum
    localparam int SUM_W = 17;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

endpackage

`default_nettype wire

// ----- src/tls_like_record_deframer_unit.sv -----
// Record deframer top level: splits a byte stream into records, at most one result per byte.
// Depends on tlsrd_pkg for header constants and result kinds.
// Results are registered: a result appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; intake stalls only while a result waits unclaimed.
// Reset (rst_n low, asynchronous): header count, length, remaining count, dead flag and
// result valid clear; the block then expects a record header.
`default_nettype none

module tls_like_record_deframer_unit
    import tlsrd_pkg::*;
#(
    parameter int MAX_FRAME = 4096
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // byte stream
    input  wire logic       rx_valid,
    output logic            rx_ready,
    input  wire logic [7:0] rx_byte,
    // results
    output logic            rec_valid,
    input  wire logic       rec_ready,
    output logic [1:0]      kind,
    output logic [7:0]      payload_byte,
    output logic            last
);

    localparam logic [SUM_W-1:0] FRAME_LIMIT = SUM_W'(MAX_FRAME);

    // Framing state
    logic [2:0]  header_count_reg, header_count_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [15:0] payload_remaining_reg, payload_remaining_next;
    logic        dead_reg, dead_next;

    // Result register
    logic        rec_valid_reg, rec_valid_next;
    kind_t       kind_reg, kind_next;
    logic [7:0]  payload_byte_reg, payload_byte_next;
    logic        last_reg, last_next;

    // Per-byte working values
    logic        rx_fire;
    logic        emit;
    kind_t       emit_kind;
    logic [7:0]  emit_byte;
    logic        emit_last;
    logic [2:0]  hdr_pos;
    logic [15:0] rec_len;
    logic [SUM_W-1:0] rec_total;

    // Accept a byte whenever the result slot is free or being drained
    assign rx_ready = !rec_valid_reg || rec_ready;
    assign rx_fire  = rx_valid && rx_ready;

    assign rec_len   = {length_high_reg, rx_byte};
    assign rec_total = {1'b0, rec_len} + SUM_W'(HEADER_LEN);

    // Decode one byte against the framing state
    always_comb
    begin
        header_count_next      = header_count_reg;
        length_high_next       = length_high_reg;
        payload_remaining_next = payload_remaining_reg;
        dead_next              = dead_reg;
        emit                   = 1'b0;
        emit_kind              = KIND_DATA;
        emit_byte              = 8'd0;
        emit_last              = 1'b0;
        hdr_pos                = (header_count_reg >= HEADER_LEN) ? HDR_TYPE : header_count_reg;

        if (!dead_reg)
        begin
            if (header_count_reg >= HEADER_LEN && payload_remaining_reg != 16'd0)
            begin
                // Pass a payload byte, close the record on the final one
                emit                   = 1'b1;
                emit_kind              = KIND_DATA;
                emit_byte              = rx_byte;
                emit_last              = (payload_remaining_reg == 16'd1);
                payload_remaining_next = payload_remaining_reg - 16'd1;
                if (payload_remaining_reg == 16'd1)
                begin
                    header_count_next = HDR_TYPE;
                end
            end
            else
            begin
                unique case (hdr_pos)
                    HDR_TYPE:
                    begin
                        if (rx_byte != TYPE_APPDATA)
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_ERROR;
                            dead_next = 1'b1;
                        end
                        else
                        begin
                            header_count_next = HDR_VER_HI;
                        end
                    end
                    HDR_VER_HI, HDR_VER_LO:
                    begin
                        header_count_next = hdr_pos + 3'd1;
                    end
                    HDR_LEN_HI:
                    begin
                        length_high_next  = rx_byte;
                        header_count_next = hdr_pos + 3'd1;
                    end
                    default:
                    begin
                        // Low length byte: check size, then report an empty record or open the payload
                        if (rec_total >= FRAME_LIMIT)
                        begin
                            emit      = 1'b1;
                            emit_kind = KIND_ERROR;
                            dead_next = 1'b1;
                        end
                        else if (rec_len == 16'd0)
                        begin
                            emit              = 1'b1;
                            emit_kind         = KIND_EMPTY;
                            emit_last         = 1'b1;
                            header_count_next = HDR_TYPE;
                        end
                        else
                        begin
                            payload_remaining_next = rec_len;
                            header_count_next      = HEADER_LEN;
                        end
                    end
                endcase
            end
        end
    end

    // Load or drain the result register
    always_comb
    begin
        rec_valid_next    = rec_valid_reg && !rec_ready;
        kind_next         = kind_reg;
        payload_byte_next = payload_byte_reg;
        last_next         = last_reg;
        if (rx_fire && emit)
        begin
            rec_valid_next    = 1'b1;
            kind_next         = emit_kind;
            payload_byte_next = emit_byte;
            last_next         = emit_last;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg      <= HDR_TYPE;
            length_high_reg       <= 8'd0;
            payload_remaining_reg <= 16'd0;
            dead_reg              <= 1'b0;
            rec_valid_reg         <= 1'b0;
        end
        else
        begin
            if (rx_fire)
            begin
                header_count_reg      <= header_count_next;
                length_high_reg       <= length_high_next;
                payload_remaining_reg <= payload_remaining_next;
                dead_reg              <= dead_next;
            end
            rec_valid_reg <= rec_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        kind_reg         <= kind_next;
        payload_byte_reg <= payload_byte_next;
        last_reg         <= last_next;
    end

    assign rec_valid    = rec_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = payload_byte_reg;
    assign last         = last_reg;

    // Once dead, the stream stays dead until reset
    a_dead_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        dead_reg |=> dead_reg)
        else $error("dead flag cleared without reset");

    // A pending error result implies the block has gone dead
    a_error_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid_reg && kind_reg == KIND_ERROR) |-> dead_reg)
        else $error("error result without dead flag");

    // A dead block produces no new result once the slot drains
    a_dead_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (dead_reg && (!rec_valid_reg || rec_ready)) |=> !rec_valid_reg)
        else $error("result produced while dead");

    // A nonzero remaining count only exists inside a payload
    a_remaining_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (payload_remaining_reg != 16'd0) |-> (header_count_reg == HEADER_LEN))
        else $error("remaining count outside payload phase");

    // Errors never carry a last mark
    a_error_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid_reg && kind_reg == KIND_ERROR) |-> !last_reg)
        else $error("error result marked last");

endmodule

`default_nettype wire
